// ===== src/acc_pkg.sv =====
// Shared types, class codes and residue lookup functions for the column
// conservation unit. No dependencies.
`default_nettype none

package acc_pkg;

  localparam int unsigned NUM_AA     = 20;
  localparam int unsigned NUM_STRONG = 9;
  localparam int unsigned NUM_WEAK   = 11;
  localparam int unsigned AA_IDX_W   = 5;

  // Conservation class as it leaves the block
  typedef enum logic [1:0] {
    SC_NONE   = 2'd0,   // blank
    SC_WEAK   = 2'd1,   // '.'
    SC_STRONG = 2'd2,   // ':'
    SC_IDENT  = 2'd3    // '*'
  } score_class_t;

  // One classified residue, handed from front to back
  typedef struct packed {
    logic                  aa_ok;       // one of the 20 standard letters
    logic [AA_IDX_W-1:0]   aa_idx;      // 0..19, zero when not aa_ok
    logic [NUM_STRONG-1:0] strong_hit;  // strong-group membership
    logic [NUM_WEAK-1:0]   weak_hit;    // weak-group membership
    logic                  last;        // closes the column
  } acc_item_t;

  // Index into ACDEFGHIKLMNPQRSTVWY, NUM_AA for anything else
  function automatic logic [AA_IDX_W-1:0] aa_index(input logic [7:0] code);
    logic [AA_IDX_W-1:0] idx;
    case (code)
      "A": idx = 5'd0;
      "C": idx = 5'd1;
      "D": idx = 5'd2;
      "E": idx = 5'd3;
      "F": idx = 5'd4;
      "G": idx = 5'd5;
      "H": idx = 5'd6;
      "I": idx = 5'd7;
      "K": idx = 5'd8;
      "L": idx = 5'd9;
      "M": idx = 5'd10;
      "N": idx = 5'd11;
      "P": idx = 5'd12;
      "Q": idx = 5'd13;
      "R": idx = 5'd14;
      "S": idx = 5'd15;
      "T": idx = 5'd16;
      "V": idx = 5'd17;
      "W": idx = 5'd18;
      "Y": idx = 5'd19;
      default: idx = AA_IDX_W'(NUM_AA);
    endcase
    return idx;
  endfunction

  // Strong groups, bit 0 up: STA NEQK NHQK NDEQ QHRK MILV MILF HY FYW
  function automatic logic [NUM_STRONG-1:0] strong_mask(input logic [7:0] code);
    logic [NUM_STRONG-1:0] m;
    case (code)
      "A":     m = 9'b000000001;
      "D":     m = 9'b000001000;
      "E":     m = 9'b000001010;
      "F":     m = 9'b101000000;
      "H":     m = 9'b010010100;
      "I":     m = 9'b001100000;
      "K":     m = 9'b000010110;
      "L":     m = 9'b001100000;
      "M":     m = 9'b001100000;
      "N":     m = 9'b000001110;
      "Q":     m = 9'b000011110;
      "R":     m = 9'b000010000;
      "S":     m = 9'b000000001;
      "T":     m = 9'b000000001;
      "V":     m = 9'b000100000;
      "W":     m = 9'b100000000;
      "Y":     m = 9'b110000000;
      default: m = '0;
    endcase
    return m;
  endfunction

  // Weak groups, bit 0 up:
  // CSA ATV SAG STNK STPA SGND SNDEQK NDEQHK NEQHRK FVLIM HFY
  function automatic logic [NUM_WEAK-1:0] weak_mask(input logic [7:0] code);
    logic [NUM_WEAK-1:0] m;
    case (code)
      "A":     m = 11'b00000010111;
      "C":     m = 11'b00000000001;
      "D":     m = 11'b00011100000;
      "E":     m = 11'b00111000000;
      "F":     m = 11'b11000000000;
      "G":     m = 11'b00000100100;
      "H":     m = 11'b10110000000;
      "I":     m = 11'b01000000000;
      "K":     m = 11'b00111001000;
      "L":     m = 11'b01000000000;
      "M":     m = 11'b01000000000;
      "N":     m = 11'b00111101000;
      "P":     m = 11'b00000010000;
      "Q":     m = 11'b00111000000;
      "R":     m = 11'b00100000000;
      "S":     m = 11'b00001111101;
      "T":     m = 11'b00000011010;
      "V":     m = 11'b01000000010;
      "Y":     m = 11'b10000000000;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== src/alignment_column_conservation_unit.sv =====
// Top level of the alignment column conservation unit: front classifier,
// residue queue and back-end scorer. Depends on acc_pkg, acc_front,
// acc_queue and acc_back.
//
// Residues of one alignment column stream in as ASCII letters, one request
// per cycle; the request with in_tlast set closes the column and produces
// one result request carrying the conservation class (0 none, 1 weak '.',
// 2 strong ':', 3 identical '*'). Anything but the upper-case letters
// ACDEFGHIKLMNPQRSTVWY counts as a gap and drives the column to none.
// Throughput is one residue per clock, sustained while the output accepts
// results, with back-to-back columns allowed. A closing residue's class
// passes through the front classifier register, a queue slot and the
// result register, in that order, before it shows on out_tvalid. The
// front, queue and back each stall independently; the queue of QUEUE_DEPTH
// entries absorbs short output stalls while input keeps flowing.
// Non-closing residues never wait on the output side.
`default_nettype none

module alignment_column_conservation_unit
  import acc_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
)(
  input  wire logic       clk,
  input  wire logic       rst_n,
  // residue channel
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] residue
  input  wire logic       in_tlast,   // column_end
  // class channel
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata   // [1:0] score_class, [7:2] zero
);

  logic      q_push_valid, q_push_ready;
  acc_item_t q_push_item;
  logic      q_pop_valid, q_pop_ready;
  acc_item_t q_pop_item;

  // Front: letter lookup and group masks, registered
  acc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .residue    (in_tdata),
    .column_end (in_tlast),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_item  (q_push_item)
  );

  // Decoupling queue
  acc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_item  (q_push_item),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_item   (q_pop_item)
  );

  // Back: column flags and result register
  acc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_item   (q_pop_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// ===== src/acc_front.sv =====
// Front stage: takes input requests and registers the classified residue.
// Depends on acc_pkg.
`default_nettype none

module acc_front
  import acc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire logic [7:0] residue,
  input  wire logic      column_end,
  output logic           push_valid,
  input  wire logic      push_ready,
  output acc_item_t      push_item
);

  logic                stage_valid_r, stage_valid_nxt;
  acc_item_t           stage_item_r;
  acc_item_t           cls_item;
  logic [AA_IDX_W-1:0] idx;

  assign idx = aa_index(residue);

  always_comb begin
    cls_item.aa_ok      = (idx != AA_IDX_W'(NUM_AA));
    cls_item.aa_idx     = cls_item.aa_ok ? idx : '0;
    cls_item.strong_hit = strong_mask(residue);
    cls_item.weak_hit   = weak_mask(residue);
    cls_item.last       = column_end;
  end

  // Stage frees up when its content moves into the queue
  assign in_tready  = !stage_valid_r || push_ready;
  assign push_valid = stage_valid_r;
  assign push_item  = stage_item_r;

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (in_tready) begin
      stage_valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
    if (in_tvalid && in_tready) begin
      stage_item_r <= cls_item;
    end
  end

endmodule

`default_nettype wire

// ===== src/acc_queue.sv =====
// Small FIFO of classified residues between front and back.
// Depends on acc_pkg.
`default_nettype none

module acc_queue
  import acc_pkg::*;
#(
  parameter int unsigned DEPTH = 4
)(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push_valid,
  output logic           push_ready,
  input  wire acc_item_t push_item,
  output logic           pop_valid,
  input  wire logic      pop_ready,
  output acc_item_t      pop_item
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  acc_item_t        slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== src/acc_back.sv =====
// Back stage: folds residues into the column flags and registers the class.
// Depends on acc_pkg.
`default_nettype none

module acc_back
  import acc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      pop_valid,
  output logic           pop_ready,
  input  wire acc_item_t pop_item,
  output logic           out_tvalid,
  input  wire logic      out_tready,
  output logic [7:0]     out_tdata
);

  logic                  started_r, started_nxt;
  logic [AA_IDX_W-1:0]   first_r, first_nxt;
  logic                  ident_r, ident_nxt;
  logic [NUM_STRONG-1:0] strong_r, strong_nxt;
  logic [NUM_WEAK-1:0]   weak_r, weak_nxt;
  logic                  out_valid_r, out_valid_nxt;
  score_class_t          out_class_r, out_class_nxt;

  logic                  upd_ident;
  logic [AA_IDX_W-1:0]   upd_first;
  logic [NUM_STRONG-1:0] upd_strong;
  logic [NUM_WEAK-1:0]   upd_weak;
  score_class_t          upd_class;
  logic                  do_pop;

  // Non-closing residues never wait on the output side
  assign pop_ready = !pop_item.last || !out_valid_r || out_tready;
  assign do_pop    = pop_valid && pop_ready;

  always_comb begin
    upd_strong = strong_r & pop_item.strong_hit;
    upd_weak   = weak_r & pop_item.weak_hit;
    if (started_r) begin
      upd_first = first_r;
      upd_ident = ident_r && pop_item.aa_ok && (pop_item.aa_idx == first_r);
    end else begin
      upd_first = pop_item.aa_idx;
      upd_ident = pop_item.aa_ok;
    end
    if (upd_ident) begin
      upd_class = SC_IDENT;
    end else if (|upd_strong) begin
      upd_class = SC_STRONG;
    end else if (|upd_weak) begin
      upd_class = SC_WEAK;
    end else begin
      upd_class = SC_NONE;
    end
  end

  always_comb begin
    started_nxt   = started_r;
    first_nxt     = first_r;
    ident_nxt     = ident_r;
    strong_nxt    = strong_r;
    weak_nxt      = weak_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_class_nxt = out_class_r;
    if (do_pop) begin
      if (pop_item.last) begin
        // column closed: emit and return to the empty-column state
        started_nxt   = 1'b0;
        first_nxt     = '0;
        ident_nxt     = 1'b1;
        strong_nxt    = '1;
        weak_nxt      = '1;
        out_valid_nxt = 1'b1;
        out_class_nxt = upd_class;
      end else begin
        started_nxt = 1'b1;
        first_nxt   = upd_first;
        ident_nxt   = upd_ident;
        strong_nxt  = upd_strong;
        weak_nxt    = upd_weak;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      first_r     <= '0;
      ident_r     <= 1'b1;
      strong_r    <= '1;
      weak_r      <= '1;
      out_valid_r <= 1'b0;
    end else begin
      started_r   <= started_nxt;
      first_r     <= first_nxt;
      ident_r     <= ident_nxt;
      strong_r    <= strong_nxt;
      weak_r      <= weak_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_class_r <= out_class_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_class_r};

`ifndef SYNTH
  a_empty_column_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !started_r |-> (ident_r && (&strong_r) && (&weak_r)))
    else $error("empty column with cleared flags");

  a_close_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && pop_item.last) |=> (!started_r && out_valid_r))
    else $error("column close did not reset state or raise result");

  a_open_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !pop_item.last) |=> started_r)
    else $error("residue did not open column");
`endif

endmodule

`default_nettype wire
